### design/mbcc_pkg.sv
// ----------------------------------------------------------------------------
// mbcc_pkg
// Shared types and constants of the multi-button click classifier.
// ----------------------------------------------------------------------------
package mbcc_pkg;

  // Register indexes (byte address = 8 * index)
  localparam logic [2:0] REG_BUTTON_COUNT = 3'd0;
  localparam logic [2:0] REG_PIN_MAP      = 3'd1;
  localparam logic [2:0] REG_ACTIVE_LEVEL = 3'd2;
  localparam logic [2:0] REG_PAUSED       = 3'd3;
  localparam logic [2:0] REG_CLICK_TIME   = 3'd4;
  localparam logic [2:0] REG_DBLCLICK     = 3'd5;
  localparam logic [2:0] REG_LONGCLICK    = 3'd6;

  // Reset values of the timing registers
  localparam logic [15:0] CLICK_TIME_RST     = 16'd50;
  localparam logic [15:0] DBLCLICK_TIME_RST  = 16'd300;
  localparam logic [15:0] LONGCLICK_TIME_RST = 16'd1000;

  // Duration saturation value
  localparam logic [15:0] DUR_MAX = 16'hFFFF;

  // Event codes of a result word
  typedef enum logic [2:0] {
    EV_PRESSED   = 3'd0,
    EV_RELEASED  = 3'd1,
    EV_CLICK     = 3'd2,
    EV_DBLCLICK  = 3'd3,
    EV_LONGCLICK = 3'd4
  } ev_code_e;

  // One stored button entry
  typedef struct packed {
    logic        held;
    logic        armed;
    logic [15:0] dur;
  } btn_entry_t;

endpackage

### design/multi_button_click_classifier_core.sv
// ----------------------------------------------------------------------------
// multi_button_click_classifier_core
// Classifies press, release, click, double click and long click per button
// from a stream of pin-change words. Button state lives in a small RAM.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                Payload
//  s_axis    in         tvalid / tready          tdata: elapsed_ms, pin_levels
//  m_axis    out        tvalid / tready, tlast   tdata: button_index, event_code
//  apb       in         psel, penable, pready=1  pwdata / prdata 64 bit
//
//  An input word is accepted in the idle state, then the buttons in use are
//  swept in order (the RAM read of the next button overlaps the update of
//  the current one), and a flush state sends the final result; a word
//  with no buttons in use is only accepted.
//  A result waiting in the output register stalls the sweep while it
//  waits when a second result must be pushed behind it, and holds the
//  flush state until the output register frees up.
//  Reset clears the per-button valid bits; the RAM itself is not swept.
// ----------------------------------------------------------------------------
module multi_button_click_classifier_core
  import mbcc_pkg::*;
#(
  parameter int MAX_BUTTONS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] elapsed_ms, [31:16] pin_levels
  // Result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [3:0] button_index, [6:4] event_code
  output logic        m_axis_tlast,   // last
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int IW = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;
  localparam logic [4:0] NMAX = 5'(MAX_BUTTONS);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  // Configuration registers
  logic [4:0]  button_count_q;
  logic [63:0] pin_map_q;
  logic [15:0] active_level_q;
  logic [15:0] paused_q;
  logic [15:0] click_time_q;
  logic [15:0] dblclick_time_q;
  logic [15:0] longclick_time_q;
  logic [MAX_BUTTONS-1:0] valid_q, valid_d;

  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [4:0]  n_eff;
  logic [4:0]  n_new;

  // Sequencer
  logic [1:0]    state_q, state_d;
  logic [IW-1:0] k_q, k_d;
  logic [15:0]   elapsed_q;
  logic [15:0]   levels_q;

  // Pending and output results
  logic           pend_valid_q, pend_valid_d;
  logic [3:0]     pend_idx_q, pend_idx_d;
  ev_code_e       pend_code_q, pend_code_d;
  logic           m_valid_q, m_valid_d;
  logic [3:0]     m_idx_q, m_idx_d;
  ev_code_e       m_code_q, m_code_d;
  logic           m_last_q, m_last_d;

  // RAM ports
  logic          ram_we, ram_re;
  logic [IW-1:0] ram_raddr;
  btn_entry_t    ram_wdata, ram_rdata;

  // Per-button update
  logic [3:0]  k4;
  logic [3:0]  pin;
  logic        vld, held, armed, pressed_lvl, paused;
  logic [15:0] dur, dur_adv;
  logic [16:0] dur_sum;
  logic        ev_valid;
  ev_code_e    ev_code;
  btn_entry_t  upd;
  logic        out_free, stall, last_btn;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = paddr[5:3];
  assign n_eff   = (button_count_q > NMAX) ? NMAX : button_count_q;
  assign n_new   = (pwdata[4:0] > NMAX) ? NMAX : pwdata[4:0];

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      button_count_q   <= '0;
      pin_map_q        <= '0;
      active_level_q   <= '0;
      paused_q         <= '0;
      click_time_q     <= CLICK_TIME_RST;
      dblclick_time_q  <= DBLCLICK_TIME_RST;
      longclick_time_q <= LONGCLICK_TIME_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_BUTTON_COUNT: button_count_q   <= pwdata[4:0];
        REG_PIN_MAP:      pin_map_q        <= pwdata;
        REG_ACTIVE_LEVEL: active_level_q   <= pwdata[15:0];
        REG_PAUSED:       paused_q         <= pwdata[15:0];
        REG_CLICK_TIME:   click_time_q     <= pwdata[15:0];
        REG_DBLCLICK:     dblclick_time_q  <= pwdata[15:0];
        REG_LONGCLICK:    longclick_time_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (cfg_idx)
      REG_BUTTON_COUNT: prdata = {59'd0, button_count_q};
      REG_PIN_MAP:      prdata = pin_map_q;
      REG_ACTIVE_LEVEL: prdata = {48'd0, active_level_q};
      REG_PAUSED:       prdata = {48'd0, paused_q};
      REG_CLICK_TIME:   prdata = {48'd0, click_time_q};
      REG_DBLCLICK:     prdata = {48'd0, dblclick_time_q};
      REG_LONGCLICK:    prdata = {48'd0, longclick_time_q};
      default:          prdata = '0;
    endcase
  end

  // Decode the current button from the RAM word
  assign k4          = 4'(k_q);
  assign pin         = pin_map_q[{k4, 2'b00} +: 4];
  assign vld         = valid_q[k_q];
  assign held        = vld & ram_rdata.held;
  assign armed       = vld & ram_rdata.armed;
  assign dur         = vld ? ram_rdata.dur : 16'd0;
  assign paused      = paused_q[k4];
  assign pressed_lvl = (levels_q[pin] == active_level_q[k4]);
  assign dur_sum     = {1'b0, dur} + {1'b0, elapsed_q};
  assign dur_adv     = (dur == 16'd0) ? 16'd0 :
                       (dur_sum >= {1'b0, DUR_MAX}) ? DUR_MAX : dur_sum[15:0];

  // Classify press, release and the click kinds; a paused button gives no event
  always_comb begin
    upd      = '{held: held, armed: armed, dur: dur_adv};
    ev_valid = 1'b0;
    ev_code  = EV_PRESSED;
    if (pressed_lvl && !held) begin
      upd.armed = (dur_adv != 16'd0) && (dur_adv <= dblclick_time_q);
      upd.held  = 1'b1;
      upd.dur   = 16'd1;
      ev_valid  = 1'b1;
      ev_code   = EV_PRESSED;
    end else if (!pressed_lvl && held) begin
      ev_valid = 1'b1;
      if (dur_adv >= longclick_time_q) begin
        ev_code = EV_LONGCLICK;
      end else if (dur_adv >= click_time_q) begin
        ev_code = armed ? EV_DBLCLICK : EV_CLICK;
      end else begin
        ev_code = EV_RELEASED;
      end
      upd.held = 1'b0;
      upd.dur  = ((dur_adv >= click_time_q) && (dur_adv < longclick_time_q)) ?
                 16'd1 : 16'd0;
    end
    if (paused) begin
      ev_valid = 1'b0;
    end
  end

  assign out_free = !m_valid_q || m_axis_tready;
  assign stall    = ev_valid && pend_valid_q && !out_free;
  assign last_btn = ((5'(k_q) + 5'd1) == n_eff);

  // Sequencer, result queue and valid bits
  always_comb begin
    state_d      = state_q;
    k_d          = k_q;
    pend_valid_d = pend_valid_q;
    pend_idx_d   = pend_idx_q;
    pend_code_d  = pend_code_q;
    m_valid_d    = m_valid_q;
    m_idx_d      = m_idx_q;
    m_code_d     = m_code_q;
    m_last_d     = m_last_q;
    valid_d      = valid_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = '0;
    ram_wdata    = upd;

    // drop a taken result
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          k_d = '0;
          if (n_eff == 5'd0) begin
            state_d = ST_IDLE;
          end else begin
            ram_re  = 1'b1;
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (!stall) begin
          if (!paused) begin
            ram_we      = 1'b1;
            valid_d[k_q] = 1'b1;
          end
          if (ev_valid) begin
            // move the older result into the output register
            if (pend_valid_q) begin
              m_valid_d = 1'b1;
              m_idx_d   = pend_idx_q;
              m_code_d  = pend_code_q;
              m_last_d  = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_idx_d   = k4;
            pend_code_d  = ev_code;
          end
          if (last_btn) begin
            state_d = ST_FLUSH;
          end else begin
            k_d       = k_q + IW'(1);
            ram_re    = 1'b1;
            ram_raddr = k_q + IW'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          m_valid_d    = 1'b1;
          m_idx_d      = pend_idx_q;
          m_code_d     = pend_code_q;
          m_last_d     = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // clear buttons dropped from use or resumed from pause
    if (cfg_we && (cfg_idx == REG_BUTTON_COUNT)) begin
      for (int j = 0; j < MAX_BUTTONS; j++) begin
        if (5'(j) >= n_new) begin
          valid_d[j] = 1'b0;
        end
      end
    end
    if (cfg_we && (cfg_idx == REG_PAUSED)) begin
      for (int j = 0; j < MAX_BUTTONS; j++) begin
        if (paused_q[j] && !pwdata[j]) begin
          valid_d[j] = 1'b0;
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      k_q          <= '0;
      pend_valid_q <= 1'b0;
      m_valid_q    <= 1'b0;
      valid_q      <= '0;
    end else begin
      state_q      <= state_d;
      k_q          <= k_d;
      pend_valid_q <= pend_valid_d;
      m_valid_q    <= m_valid_d;
      valid_q      <= valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      elapsed_q <= s_axis_tdata[15:0];
      levels_q  <= s_axis_tdata[31:16];
    end
    pend_idx_q  <= pend_idx_d;
    pend_code_q <= pend_code_d;
    m_idx_q     <= m_idx_d;
    m_code_q    <= m_code_d;
    m_last_q    <= m_last_d;
  end

  // Button state store
  mbcc_ram #(
    .WIDTH($bits(btn_entry_t)),
    .DEPTH(MAX_BUTTONS)
  ) u_state_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(k_q),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, m_code_q, m_idx_q};
  assign m_axis_tlast  = m_last_q;

`ifndef SYNTHESIS
  // No result is left pending once the block takes a new word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_valid_q)
    else $error("pending result left over in idle");

  // The store is written only during the sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_RUN))
    else $error("state store written outside the sweep");

  // The sweep never visits a button beyond the count in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (5'(k_q) < n_eff))
    else $error("sweep index beyond buttons in use");

  // A flush always ends the word within the cycle the output frees up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FLUSH) && out_free) |=> (state_q == ST_IDLE))
    else $error("flush did not complete");
`endif

endmodule

### design/mbcc_ram.sv
// ----------------------------------------------------------------------------
// mbcc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mbcc_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held while the read is not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sim/tb_multi_button_click_classifier_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_button_click_classifier_core
// Self-checking bench for the click classifier. Pin-change words are sent in
// random bursts while the event stream stalls on its own pattern. A
// behavioral copy of the per-button state machine predicts every event word,
// and each arriving word is checked field by field against the oldest
// prediction. Registers are written over APB only while the core is idle and
// read back after each write to a mapped index.
// ----------------------------------------------------------------------------
module tb_multi_button_click_classifier_core;
  import mbcc_pkg::*;

  localparam int          NUM_BUTTONS  = 16;
  localparam int          SWEEP_SLACK  = 48;
  localparam logic [2:0]  REG_UNUSED   = 3'd7;
  localparam logic [63:0] IDENTITY_MAP = 64'hFEDC_BA98_7654_3210;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_SPARSE,
    RDY_PATTERN
  } rdy_mode_e;

  // One predicted event word
  typedef struct packed {
    logic [3:0] btn;
    ev_code_e   code;
    logic       last;
  } click_event_t;

  // Block ports
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;   // [15:0] elapsed_ms, [31:16] pin_levels
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;         // [3:0] button_index, [6:4] event_code
  logic        m_axis_tlast;         // last
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [5:0]  paddr         = '0;
  logic [63:0] pwdata        = '0;
  logic [63:0] prdata;
  logic        pready;

  // Predicted configuration
  logic [4:0]  m_count   = 5'd0;
  logic [63:0] m_pin_map = '0;
  logic [15:0] m_active  = '0;
  logic [15:0] m_paused  = '0;
  logic [15:0] m_click   = CLICK_TIME_RST;
  logic [15:0] m_dbl     = DBLCLICK_TIME_RST;
  logic [15:0] m_long    = LONGCLICK_TIME_RST;

  // Predicted per-button state
  logic        m_held [NUM_BUTTONS];
  logic        m_armed[NUM_BUTTONS];
  logic [15:0] m_dur  [NUM_BUTTONS];

  click_event_t pending_events[$];
  click_event_t want_ev;
  int          mismatches = 0;
  int          burst_left = 0;
  logic [15:0] cur_levels = '0;
  rdy_mode_e   rdy_mode   = RDY_ALWAYS;
  int          rdy_left   = 0;
  logic [7:0]  rdy_pat    = 8'hFF;

  multi_button_click_classifier_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch: %s expected %0h got %0h", what, want, got);
  endtask

  // Advance every unpaused button in use by one pin-change word and queue its events
  task automatic classify_word(input logic [15:0] elapsed, input logic [15:0] levels);
    int           n;
    int           cnt;
    int           k;
    logic [16:0]  sum;
    logic [15:0]  d;
    logic [3:0]   pin;
    logic         hit;
    ev_code_e     code;
    click_event_t batch[NUM_BUTTONS];
    n = (m_count > NUM_BUTTONS) ? NUM_BUTTONS : int'(m_count);
    cnt = 0;
    code = EV_PRESSED;
    for (k = 0; k < n; k++) begin
      if (m_paused[k]) continue;
      d = m_dur[k];
      if (d != 16'd0) begin
        sum = {1'b0, d} + {1'b0, elapsed};
        d = (sum >= {1'b0, DUR_MAX}) ? DUR_MAX : sum[15:0];
      end
      pin = m_pin_map[4*k +: 4];
      hit = 1'b0;
      if (levels[pin] == m_active[k]) begin
        if (!m_held[k]) begin
          m_armed[k] = (d != 16'd0) && (d <= m_dbl);
          m_held[k]  = 1'b1;
          d    = 16'd1;
          code = EV_PRESSED;
          hit  = 1'b1;
        end
      end else if (m_held[k]) begin
        if (d >= m_long)       code = EV_LONGCLICK;
        else if (d >= m_click) code = m_armed[k] ? EV_DBLCLICK : EV_CLICK;
        else                   code = EV_RELEASED;
        m_held[k] = 1'b0;
        d   = (d >= m_click && d < m_long) ? 16'd1 : 16'd0;
        hit = 1'b1;
      end
      m_dur[k] = d;
      if (hit) begin
        batch[cnt].btn  = 4'(k);
        batch[cnt].code = code;
        batch[cnt].last = 1'b0;
        cnt++;
      end
    end
    for (k = 0; k < cnt; k++) begin
      if (k == cnt - 1) batch[k].last = 1'b1;
      pending_events.push_back(batch[k]);
    end
  endtask

  function automatic logic [63:0] model_reg(input logic [2:0] idx);
    case (idx)
      REG_BUTTON_COUNT: return {59'd0, m_count};
      REG_PIN_MAP:      return m_pin_map;
      REG_ACTIVE_LEVEL: return {48'd0, m_active};
      REG_PAUSED:       return {48'd0, m_paused};
      REG_CLICK_TIME:   return {48'd0, m_click};
      REG_DBLCLICK:     return {48'd0, m_dbl};
      REG_LONGCLICK:    return {48'd0, m_long};
      default:          return 64'd0;
    endcase
  endfunction

  function automatic logic [63:0] reg_mask(input logic [2:0] idx);
    case (idx)
      REG_BUTTON_COUNT: return 64'h1F;
      REG_PIN_MAP:      return '1;
      default:          return 64'hFFFF;
    endcase
  endfunction

  // One APB transfer: setup cycle, then access until pready
  task automatic apb_access(input logic wr, input logic [2:0] idx,
                            input logic [63:0] wdata, output logic [63:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 3'b000};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_reg(input logic [2:0] idx);
    logic [63:0] got;
    apb_access(1'b0, idx, 64'd0, got);
    if ((got & reg_mask(idx)) != model_reg(idx))
      note_mismatch($sformatf("register %0d readback", idx), model_reg(idx),
                    got & reg_mask(idx));
  endtask

  task automatic check_all_regs();
    for (int i = 0; i <= int'(REG_LONGCLICK); i++) check_reg(3'(i));
  endtask

  // Drop input valid, drain predicted events, then let any silent sweep end
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (SWEEP_SLACK) @(posedge clk_i);
  endtask

  // Write a register while idle and mirror its side effects on button state
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    logic [63:0] unused;
    int          n;
    wait_idle();
    apb_access(1'b1, idx, value, unused);
    case (idx)
      REG_BUTTON_COUNT: begin
        m_count = value[4:0];
        n = (m_count > NUM_BUTTONS) ? NUM_BUTTONS : int'(m_count);
        for (int k = n; k < NUM_BUTTONS; k++) begin
          m_held[k] = 1'b0; m_armed[k] = 1'b0; m_dur[k] = 16'd0;
        end
      end
      REG_PIN_MAP:      m_pin_map = value;
      REG_ACTIVE_LEVEL: m_active  = value[15:0];
      REG_PAUSED: begin
        for (int k = 0; k < NUM_BUTTONS; k++)
          if (m_paused[k] && !value[k]) begin
            m_held[k] = 1'b0; m_armed[k] = 1'b0; m_dur[k] = 16'd0;
          end
        m_paused = value[15:0];
      end
      REG_CLICK_TIME:   m_click = value[15:0];
      REG_DBLCLICK:     m_dbl   = value[15:0];
      REG_LONGCLICK:    m_long  = value[15:0];
      default: ;
    endcase
    if (idx != REG_UNUSED) check_reg(idx);
  endtask

  // Send one pin-change word, with a random gap at the start of each burst
  task automatic send_word(input logic [15:0] elapsed, input logic [15:0] levels);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 8);
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tdata  <= {levels, elapsed};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    classify_word(elapsed, levels);
  endtask

  // Receiver stall pattern: switch mode after a random stretch
  always @(negedge clk_i) begin
    if (rdy_left == 0) begin
      rdy_mode = rdy_mode_e'($urandom_range(0, 3));
      rdy_left = $urandom_range(8, 80);
      rdy_pat  = 8'($urandom) | 8'h01;
    end
    rdy_left--;
    case (rdy_mode)
      RDY_ALWAYS: m_axis_tready <= 1'b1;
      RDY_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
      RDY_SPARSE: m_axis_tready <= ($urandom_range(0, 4) == 0);
      default:    m_axis_tready <= rdy_pat[rdy_left % 8];
    endcase
  end

  // Compare each accepted event word with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_events.size() == 0) begin
        note_mismatch("unexpected event word", 64'd0, {55'd0, m_axis_tlast, m_axis_tdata});
      end else begin
        want_ev = pending_events.pop_front();
        if (m_axis_tdata[3:0] != want_ev.btn)
          note_mismatch("button_index", 64'(want_ev.btn), 64'(m_axis_tdata[3:0]));
        if (m_axis_tdata[6:4] != want_ev.code)
          note_mismatch("event_code", 64'(want_ev.code), 64'(m_axis_tdata[6:4]));
        if (m_axis_tlast != want_ev.last)
          note_mismatch("last", 64'(want_ev.last), 64'(m_axis_tlast));
      end
    end
  end

  function automatic logic [15:0] pick_elapsed();
    case ($urandom_range(0, 7))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      3:       return m_click - 16'($urandom_range(0, 2));
      4:       return m_dbl - 16'($urandom_range(0, 2));
      5:       return m_long - 16'($urandom_range(0, 2));
      default: return 16'($urandom_range(0, 120));
    endcase
  endfunction

  // Counter is zero after reset: words must produce no events
  task automatic test_reset_defaults();
    check_all_regs();
    send_word(16'd1234, 16'hFFFF);
    send_word(16'd0, 16'h0000);
  endtask

  // Press, release, click, double click, long click, thresholds, saturation
  task automatic test_click_kinds();
    write_reg(REG_BUTTON_COUNT, 64'd16);
    write_reg(REG_PIN_MAP, IDENTITY_MAP);
    write_reg(REG_ACTIVE_LEVEL, 64'hFFFF);
    write_reg(REG_PAUSED, 64'h0000);
    send_word(16'd0, 16'hFFFF);
    send_word(16'd10, 16'h0000);
    send_word(16'd0, 16'hFFFF);
    send_word(16'd100, 16'h0000);
    send_word(16'd50, 16'hFFFF);
    send_word(16'd100, 16'h0000);
    send_word(16'hFFFF, 16'hFFFF);
    send_word(16'hFFFF, 16'h0000);
    send_word(16'd0, 16'h0000);
    send_word(16'd0, 16'h00FF);
    send_word(16'd999, 16'hFF00);
    send_word(16'd48, 16'hFF00);
    send_word(16'd0, 16'h0000);
    send_word(16'd0, 16'h0001);
    send_word(16'd49, 16'h0000);
    send_word(16'd299, 16'h0001);
    send_word(16'd49, 16'h0000);
  endtask

  // Count above the maximum, reversed and shared pins, mixed polarity
  task automatic test_mapping_and_polarity();
    write_reg(REG_BUTTON_COUNT, 64'd31);
    write_reg(REG_PIN_MAP, 64'h0123_4567_89AB_CDEF);
    write_reg(REG_ACTIVE_LEVEL, 64'h5555);
    send_word(16'd7, 16'hFFFF);
    send_word(16'd200, 16'h0000);
    send_word(16'($urandom), 16'($urandom));
    write_reg(REG_BUTTON_COUNT, 64'd3);
    write_reg(REG_PIN_MAP, 64'd0);
    write_reg(REG_ACTIVE_LEVEL, 64'h0005);
    send_word(16'd5, 16'h0001);
    send_word(16'd5, 16'h0000);
  endtask

  // Paused buttons keep state; resuming clears it
  task automatic test_pause_resume();
    write_reg(REG_BUTTON_COUNT, 64'd4);
    write_reg(REG_PIN_MAP, IDENTITY_MAP);
    write_reg(REG_ACTIVE_LEVEL, 64'hFFFF);
    send_word(16'd0, 16'h000F);
    write_reg(REG_PAUSED, 64'h0005);
    send_word(16'd100, 16'h0000);
    write_reg(REG_PAUSED, 64'h0000);
    send_word(16'd0, 16'h0000);
    send_word(16'd0, 16'h000F);
    send_word(16'd60, 16'h0000);
  endtask

  // A write to an unmapped index must leave everything untouched
  task automatic test_unknown_register();
    write_reg(REG_UNUSED, {32'($urandom), 32'($urandom)});
    check_all_regs();
    send_word(16'd20, 16'h0003);
  endtask

  // Random setups, each followed by mostly well-formed toggling of live pins
  task automatic test_random_phases(input int phases, input int words);
    int          n;
    int          sent;
    logic [15:0] lv;
    for (int p = 0; p < phases; p++) begin
      case ($urandom_range(0, 9))
        0:       write_reg(REG_BUTTON_COUNT, 64'd0);
        1:       write_reg(REG_BUTTON_COUNT, 64'($urandom_range(17, 31)));
        2:       write_reg(REG_BUTTON_COUNT, 64'd16);
        default: write_reg(REG_BUTTON_COUNT, 64'($urandom_range(1, 16)));
      endcase
      write_reg(REG_PIN_MAP, ($urandom_range(0, 1) == 0) ? IDENTITY_MAP
                                                        : {32'($urandom), 32'($urandom)});
      write_reg(REG_ACTIVE_LEVEL, 64'($urandom) & 64'hFFFF);
      write_reg(REG_PAUSED, ($urandom_range(0, 2) == 0) ? 64'd0
                            : 64'($urandom & $urandom & $urandom) & 64'hFFFF);
      case ($urandom_range(0, 3))
        0: begin
          write_reg(REG_CLICK_TIME, 64'($urandom_range(2, 40)));
          write_reg(REG_DBLCLICK, 64'($urandom_range(10, 150)));
          write_reg(REG_LONGCLICK, 64'($urandom_range(60, 400)));
        end
        1: begin
          write_reg(REG_CLICK_TIME, 64'($urandom_range(0, 200)));
          write_reg(REG_DBLCLICK, 64'($urandom_range(0, 1000)));
          write_reg(REG_LONGCLICK, 64'($urandom_range(0, 3000)));
        end
        2: begin
          write_reg(REG_CLICK_TIME, $urandom_range(0, 1) ? 64'hFFFF : 64'd0);
          write_reg(REG_DBLCLICK, $urandom_range(0, 1) ? 64'hFFFF : 64'd0);
          write_reg(REG_LONGCLICK, $urandom_range(0, 1) ? 64'hFFFF : 64'd0);
        end
        default: begin
          write_reg(REG_CLICK_TIME, 64'($urandom) & 64'hFFFF);
          write_reg(REG_DBLCLICK, 64'($urandom) & 64'hFFFF);
          write_reg(REG_LONGCLICK, 64'($urandom) & 64'hFFFF);
        end
      endcase
      n = (m_count > NUM_BUTTONS) ? NUM_BUTTONS : int'(m_count);
      sent = 0;
      while (sent < words) begin
        lv = cur_levels;
        case ($urandom_range(0, 9))
          // unchanged levels: noise, not counted
          0: ;
          1: lv = 16'($urandom);
          default: begin
            if (n > 0) lv[m_pin_map[4*$urandom_range(0, n - 1) +: 4]] ^= 1'b1;
            if ($urandom_range(0, 2) == 0) lv[$urandom_range(0, 15)] ^= 1'b1;
          end
        endcase
        if (lv != cur_levels) sent++;
        cur_levels = lv;
        send_word(pick_elapsed(), lv);
      end
    end
  endtask

  // Hard stop on a hang
  initial begin
    #2_000_000;
    $display("multi_button_click_classifier_core verification failed");
    $finish;
  end

  initial begin
    for (int k = 0; k < NUM_BUTTONS; k++) begin
      m_held[k] = 1'b0; m_armed[k] = 1'b0; m_dur[k] = 16'd0;
    end
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_click_kinds();
    test_mapping_and_polarity();
    test_pause_resume();
    test_unknown_register();
    test_random_phases(5, 22);
    wait_idle();
    if (mismatches == 0)
      $display("multi_button_click_classifier_core verification clean");
    else
      $display("multi_button_click_classifier_core verification failed");
    $finish;
  end

endmodule
